>>> rtl/core/dmd_pkg.sv
// Shared types, constants and helpers for the dual motor drive block.
`timescale 1ns / 1ps

package dmd_pkg;

    // Fixed field widths
    localparam int PWM_W  = 8;
    localparam int TIME_W = 16;
    localparam int REQ_W  = 2;

    // Reset values
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd250;
    localparam logic [TIME_W-1:0] PHASE_RESET   = 16'd50;

    // Item kinds carried on tuser
    localparam logic MODE_CMD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Pulsed mode request codes; any other code keeps the mode
    localparam logic [REQ_W-1:0] PULSE_OFF = 2'd0;
    localparam logic [REQ_W-1:0] PULSE_ON  = 2'd1;

    // One input beat, unpacked
    typedef struct packed {
        logic              mode;
        logic [PWM_W-1:0]  lf_pwm;
        logic [PWM_W-1:0]  lb_pwm;
        logic [PWM_W-1:0]  rf_pwm;
        logic [PWM_W-1:0]  rb_pwm;
        logic              turn_left;
        logic              turn_right;
        logic [REQ_W-1:0]  pulse_req;
        logic              disconnect;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
    } item_t;

    // The four drive levels
    typedef struct packed {
        logic [PWM_W-1:0] lf;
        logic [PWM_W-1:0] lb;
        logic [PWM_W-1:0] rf;
        logic [PWM_W-1:0] rb;
    } drive_t;

    // Result of driving one bridge side from its two requests
    typedef struct packed {
        logic [PWM_W-1:0] fwd;
        logic [PWM_W-1:0] bwd;
        logic             driven;
    } side_t;

    // Forward wins, then backward, else off
    function automatic side_t side_drive(input logic [PWM_W-1:0] fwd,
                                         input logic [PWM_W-1:0] bwd);
        side_t s;
        s.fwd    = '0;
        s.bwd    = '0;
        s.driven = 1'b0;
        if (fwd != '0)
        begin
            s.fwd    = fwd;
            s.driven = 1'b1;
        end
        else if (bwd != '0)
        begin
            s.bwd    = bwd;
            s.driven = 1'b1;
        end
        return s;
    endfunction

endpackage

>>> rtl/core/dmd_in_reg.sv
// Input register: takes one beat from the slave side and unpacks it.
`timescale 1ns / 1ps

module dmd_in_reg
    import dmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // lf_pwm[7:0], lb_pwm[15:8], rf_pwm[23:16], rb_pwm[31:24], turn_left[32],
    // turn_right[33], pulse_mode_request[35:34], disconnect[36],
    // on_time_ms[52:37], off_time_ms[68:53], zero pad[71:69]
    input  logic [71:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    input  logic        take,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  load;

    // Accept when empty or when the held beat moves on this cycle
    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    // Unpack the incoming beat
    always_comb
    begin
        item_next.mode       = s_tuser;
        item_next.lf_pwm     = s_tdata[7:0];
        item_next.lb_pwm     = s_tdata[15:8];
        item_next.rf_pwm     = s_tdata[23:16];
        item_next.rb_pwm     = s_tdata[31:24];
        item_next.turn_left  = s_tdata[32];
        item_next.turn_right = s_tdata[33];
        item_next.pulse_req  = s_tdata[35:34];
        item_next.disconnect = s_tdata[36];
        item_next.on_time    = s_tdata[52:37];
        item_next.off_time   = s_tdata[68:53];
    end

    // Hold, refill or drop the valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/core/dmd_step.sv
// Drive state, deadman and rotation timers, and the per-beat state update.
`timescale 1ns / 1ps

module dmd_step
    import dmd_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_load,
    input  logic [TIME_W-1:0] cfg_timeout,
    input  logic              advance,
    input  item_t             item,
    output drive_t            drive_next
);

    localparam int CMP_W = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;

    logic [TIME_W-1:0]     timeout_reg;
    drive_t                drive_reg;
    drive_t                pwm_reg,        pwm_next;
    logic                  turn_l_reg,     turn_l_next;
    logic                  turn_r_reg,     turn_r_next;
    logic                  pulsed_reg,     pulsed_next;
    logic [TIME_W-1:0]     on_time_reg,    on_time_next;
    logic [TIME_W-1:0]     off_time_reg,   off_time_next;
    logic [TIMER_BITS-1:0] rot_count_reg,  rot_count_next;
    logic [TIME_W-1:0]     rot_period_reg, rot_period_next;
    logic                  rot_armed_reg,  rot_armed_next;
    logic                  rot_phase_reg,  rot_phase_next;
    logic [TIMER_BITS-1:0] l_count_reg,    l_count_next;
    logic                  l_armed_reg,    l_armed_next;
    logic [TIMER_BITS-1:0] r_count_reg,    r_count_next;
    logic                  r_armed_reg,    r_armed_next;

    function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] c);
        return (c != '1) ? c + 1'b1 : c;
    endfunction

    // Next state for one beat
    always_comb
    begin
        side_t left_s;
        side_t right_s;
        logic  apply;
        logic  was_turn;
        logic  new_turn;

        drive_next      = drive_reg;
        pwm_next        = pwm_reg;
        turn_l_next     = turn_l_reg;
        turn_r_next     = turn_r_reg;
        pulsed_next     = pulsed_reg;
        on_time_next    = on_time_reg;
        off_time_next   = off_time_reg;
        rot_count_next  = rot_count_reg;
        rot_period_next = rot_period_reg;
        rot_armed_next  = rot_armed_reg;
        rot_phase_next  = rot_phase_reg;
        l_count_next    = l_count_reg;
        l_armed_next    = l_armed_reg;
        r_count_next    = r_count_reg;
        r_armed_next    = r_armed_reg;
        apply           = 1'b0;
        was_turn        = turn_l_reg || turn_r_reg;
        new_turn        = item.turn_left || item.turn_right;
        left_s          = side_drive(pwm_reg.lf, pwm_reg.lb);
        right_s         = side_drive(pwm_reg.rf, pwm_reg.rb);

        if (item.mode == MODE_TICK)
        begin
            // Advance all counts, then service rotation and deadman timers
            rot_count_next = bump(rot_count_reg);
            l_count_next   = bump(l_count_reg);
            r_count_next   = bump(r_count_reg);
            if (was_turn && rot_armed_reg &&
                CMP_W'(rot_count_next) >= CMP_W'(rot_period_reg))
            begin
                rot_phase_next = !rot_phase_reg;
                if (!rot_phase_reg)
                begin
                    drive_next      = '0;
                    rot_period_next = off_time_reg;
                end
                else
                begin
                    drive_next      = '{left_s.fwd, left_s.bwd, right_s.fwd, right_s.bwd};
                    l_armed_next    = left_s.driven;
                    l_count_next    = '0;
                    r_armed_next    = right_s.driven;
                    r_count_next    = '0;
                    rot_period_next = on_time_reg;
                end
                rot_count_next = '0;
                rot_armed_next = 1'b1;
            end
            if (l_armed_next && CMP_W'(l_count_next) >= CMP_W'(timeout_reg))
            begin
                drive_next.lf = '0;
                drive_next.lb = '0;
            end
            if (r_armed_next && CMP_W'(r_count_next) >= CMP_W'(timeout_reg))
            begin
                drive_next.rf = '0;
                drive_next.rb = '0;
            end
        end
        else
        begin
            // Pulse request applies even on disconnect
            if (item.pulse_req == PULSE_ON)
            begin
                pulsed_next = 1'b1;
            end
            else if (item.pulse_req == PULSE_OFF)
            begin
                pulsed_next = 1'b0;
            end

            if (item.disconnect)
            begin
                rot_armed_next = 1'b0;
                drive_next     = '0;
                l_armed_next   = 1'b0;
                r_armed_next   = 1'b0;
            end
            else
            begin
                if (item.on_time != '0)
                begin
                    on_time_next = item.on_time;
                end
                if (item.off_time != '0)
                begin
                    off_time_next = item.off_time;
                end
                pwm_next    = '{item.lf_pwm, item.lb_pwm, item.rf_pwm, item.rb_pwm};
                turn_l_next = item.turn_left;
                turn_r_next = item.turn_right;
                apply       = 1'b1;
                if (pulsed_next)
                begin
                    if (new_turn)
                    begin
                        if (was_turn)
                        begin
                            // Continued turn: re-arm deadmen, leave drives
                            l_count_next = '0;
                            l_armed_next = 1'b1;
                            r_count_next = '0;
                            r_armed_next = 1'b1;
                            apply        = 1'b0;
                        end
                        else
                        begin
                            rot_phase_next  = 1'b0;
                            rot_period_next = on_time_next;
                            rot_count_next  = '0;
                            rot_armed_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        rot_armed_next = 1'b0;
                    end
                end
                if (apply)
                begin
                    left_s       = side_drive(item.lf_pwm, item.lb_pwm);
                    right_s      = side_drive(item.rf_pwm, item.rb_pwm);
                    drive_next   = '{left_s.fwd, left_s.bwd, right_s.fwd, right_s.bwd};
                    l_armed_next = left_s.driven;
                    l_count_next = '0;
                    r_armed_next = right_s.driven;
                    r_count_next = '0;
                end
            end
        end
    end

    // Deadman period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_load)
        begin
            timeout_reg <= cfg_timeout;
        end
    end

    // Commit the update when a beat moves through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg      <= '0;
            pwm_reg        <= '0;
            turn_l_reg     <= 1'b0;
            turn_r_reg     <= 1'b0;
            pulsed_reg     <= 1'b0;
            on_time_reg    <= PHASE_RESET;
            off_time_reg   <= PHASE_RESET;
            rot_count_reg  <= '0;
            rot_period_reg <= PHASE_RESET;
            rot_armed_reg  <= 1'b0;
            rot_phase_reg  <= 1'b0;
            l_count_reg    <= '0;
            l_armed_reg    <= 1'b0;
            r_count_reg    <= '0;
            r_armed_reg    <= 1'b0;
        end
        else if (advance)
        begin
            drive_reg      <= drive_next;
            pwm_reg        <= pwm_next;
            turn_l_reg     <= turn_l_next;
            turn_r_reg     <= turn_r_next;
            pulsed_reg     <= pulsed_next;
            on_time_reg    <= on_time_next;
            off_time_reg   <= off_time_next;
            rot_count_reg  <= rot_count_next;
            rot_period_reg <= rot_period_next;
            rot_armed_reg  <= rot_armed_next;
            rot_phase_reg  <= rot_phase_next;
            l_count_reg    <= l_count_next;
            l_armed_reg    <= l_armed_next;
            r_count_reg    <= r_count_next;
            r_armed_reg    <= r_armed_next;
        end
    end

endmodule

>>> rtl/core/dmd_out_reg.sv
// Result register: holds one beat of drive levels for the master side.
`timescale 1ns / 1ps

module dmd_out_reg
    import dmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  drive_t      drive,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_forward_drive[7:0], left_backward_drive[15:8],
    // right_forward_drive[23:16], right_backward_drive[31:24]
    output logic [31:0] m_tdata
);

    logic   valid_reg;
    logic   valid_next;
    drive_t data_reg;

    // Free when empty or when the held beat leaves this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= drive;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.rb, data_reg.rf, data_reg.lb, data_reg.lf};

endmodule

>>> rtl/core/dual_motor_drive_with_pulsed_turn.sv
// Top level of the dual motor drive with deadman timers and pulsed turning.
// A beat moves from the input register through the single state-update stage
// into the result register, and waits while the result register is full.
// Throughput: one beat per cycle while m_tready is high.
// Reset: rst_n clears all drives, timers and flags, phase lengths to 50 ms and
// the deadman period to 250 ms; no result is pending after reset.
`timescale 1ns / 1ps

module dual_motor_drive_with_pulsed_turn
    import dmd_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    // motor_timeout_ms[15:0]
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // lf_pwm[7:0], lb_pwm[15:8], rf_pwm[23:16], rb_pwm[31:24], turn_left[32],
    // turn_right[33], pulse_mode_request[35:34], disconnect[36],
    // on_time_ms[52:37], off_time_ms[68:53], zero pad[71:69]
    input  logic [71:0] s_tdata,
    // mode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_forward_drive[7:0], left_backward_drive[15:8],
    // right_forward_drive[23:16], right_backward_drive[31:24]
    output logic [31:0] m_tdata
);

    logic   item_valid;
    item_t  item;
    logic   out_free;
    logic   advance;
    drive_t drive_next;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    // Move a held beat through when the result register can take it
    assign advance = item_valid && out_free;

    dmd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dmd_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_load    (cfg_valid),
        .cfg_timeout (cfg_data),
        .advance     (advance),
        .item        (item),
        .drive_next  (drive_next)
    );

    dmd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .drive    (drive_next),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> tb/tb_dual_motor_drive_with_pulsed_turn.sv
// Self-checking testbench for the dual motor drive with deadman timers and pulsed turning.
`timescale 1ns / 1ps

module tb_dual_motor_drive_with_pulsed_turn
    import dmd_pkg::*;
();

    localparam int          CNT_W        = 16;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned ITEM_BUDGET  = 1950;
    localparam int          NUM_PHASES   = 7;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Request codes that leave the pulsed mode as it is
    localparam logic [REQ_W-1:0] PULSE_KEEP     = 2'd2;
    localparam logic [REQ_W-1:0] PULSE_KEEP_ALT = 2'd3;

    // Tracks the drive state beat by beat and checks each result beat
    class drive_scoreboard;
        logic [TIME_W-1:0] timeout_ms;
        drive_t            levels;
        logic [PWM_W-1:0]  req_lf, req_lb, req_rf, req_rb;
        logic [1:0]        turn;
        bit                pulsed;
        logic [TIME_W-1:0] on_ms, off_ms;
        logic [CNT_W-1:0]  rot_cnt, rot_period, left_cnt, right_cnt;
        bit                rot_armed, rot_phase, left_armed, right_armed;
        drive_t            expected_levels[$];
        int unsigned       mismatches;

        function new();
            timeout_ms  = TIMEOUT_RESET;
            levels      = '0;
            req_lf      = '0;
            req_lb      = '0;
            req_rf      = '0;
            req_rb      = '0;
            turn        = '0;
            pulsed      = 1'b0;
            on_ms       = PHASE_RESET;
            off_ms      = PHASE_RESET;
            rot_cnt     = '0;
            rot_period  = PHASE_RESET;
            left_cnt    = '0;
            right_cnt   = '0;
            rot_armed   = 1'b0;
            rot_phase   = 1'b0;
            left_armed  = 1'b0;
            right_armed = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_timeout(input logic [TIME_W-1:0] value);
            timeout_ms = value;
        endfunction

        function int unsigned pending();
            return expected_levels.size();
        endfunction

        function bit failed();
            return (mismatches != 0) || (expected_levels.size() != 0);
        endfunction

        // Forward wins, then backward, else the side is off
        function bit drive_one(input logic [PWM_W-1:0] fwd, input logic [PWM_W-1:0] bwd,
                               output logic [PWM_W-1:0] f, output logic [PWM_W-1:0] b);
            f = '0;
            b = '0;
            if (fwd != '0)
            begin
                f = fwd;
                return 1'b1;
            end
            if (bwd != '0)
            begin
                b = bwd;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Drive both sides from the held requests and restart their deadmen
        function void load_sides();
            logic [PWM_W-1:0] f, b;
            left_armed  = drive_one(req_lf, req_lb, f, b);
            levels.lf   = f;
            levels.lb   = b;
            left_cnt    = '0;
            right_armed = drive_one(req_rf, req_rb, f, b);
            levels.rf   = f;
            levels.rb   = b;
            right_cnt   = '0;
        endfunction

        function logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        // One millisecond: advance counts, then rotation, then left and right deadman
        function void advance_ms();
            rot_cnt   = sat_inc(rot_cnt);
            left_cnt  = sat_inc(left_cnt);
            right_cnt = sat_inc(right_cnt);
            if (turn != '0 && rot_armed && rot_cnt >= rot_period)
            begin
                rot_phase = !rot_phase;
                if (rot_phase)
                begin
                    levels     = '0;
                    rot_period = off_ms;
                end
                else
                begin
                    load_sides();
                    rot_period = on_ms;
                end
                rot_cnt   = '0;
                rot_armed = 1'b1;
            end
            if (left_armed && left_cnt >= timeout_ms)
            begin
                levels.lf = '0;
                levels.lb = '0;
            end
            if (right_armed && right_cnt >= timeout_ms)
            begin
                levels.rf = '0;
                levels.rb = '0;
            end
        endfunction

        function void apply_command(input item_t it);
            bit was_turn;
            if (it.pulse_req == PULSE_ON)
                pulsed = 1'b1;
            else if (it.pulse_req == PULSE_OFF)
                pulsed = 1'b0;
            // Link lost: stop everything, keep the held command
            if (it.disconnect)
            begin
                rot_armed   = 1'b0;
                levels      = '0;
                left_armed  = 1'b0;
                right_armed = 1'b0;
                return;
            end
            if (it.on_time != '0)
                on_ms = it.on_time;
            if (it.off_time != '0)
                off_ms = it.off_time;
            was_turn = (turn != '0);
            req_lf   = it.lf_pwm;
            req_lb   = it.lb_pwm;
            req_rf   = it.rf_pwm;
            req_rb   = it.rb_pwm;
            turn     = {it.turn_right, it.turn_left};
            if (pulsed)
            begin
                if (turn != '0)
                begin
                    // A continued turn only refreshes the deadmen
                    if (was_turn)
                    begin
                        left_cnt    = '0;
                        left_armed  = 1'b1;
                        right_cnt   = '0;
                        right_armed = 1'b1;
                        return;
                    end
                    rot_phase  = 1'b0;
                    rot_period = on_ms;
                    rot_cnt    = '0;
                    rot_armed  = 1'b1;
                end
                else
                begin
                    rot_armed = 1'b0;
                end
            end
            load_sides();
        endfunction

        function void note_item(input item_t it);
            if (it.mode == MODE_TICK)
                advance_ms();
            else
                apply_command(it);
            expected_levels.push_back(levels);
        endfunction

        function void check_levels(input drive_t got);
            drive_t want;
            if (expected_levels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: lf=%0d lb=%0d rf=%0d rb=%0d",
                             $time, got.lf, got.lb, got.rf, got.rb);
                return;
            end
            want = expected_levels.pop_front();
            if (got.lf !== want.lf || got.lb !== want.lb ||
                got.rf !== want.rf || got.rb !== want.rb)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected lf/lb/rf/rb %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                             $time, want.lf, want.lb, want.rf, want.rb,
                             got.lf, got.lb, got.rf, got.rb);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    drive_scoreboard   drive_sb;
    int unsigned       cycles = 0;
    int unsigned       tx_calm;
    int unsigned       rx_calm;
    int unsigned       rx_stall;
    logic [TIME_W-1:0] cur_timeout;
    logic [1:0]        last_turn;
    logic [TIME_W-1:0] phase_timeout [NUM_PHASES];

    dual_motor_drive_with_pulsed_turn dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_dual_motor_drive_with_pulsed_turn: FAIL");
            $finish;
        end
    end

    // Watch every handshake at the rising edge
    always @(posedge clk)
    begin : watch_beats
        item_t  seen;
        drive_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                drive_sb.set_timeout(cfg_data);
            if (m_tvalid && m_tready)
            begin
                got.lf = m_tdata[7:0];
                got.lb = m_tdata[15:8];
                got.rf = m_tdata[23:16];
                got.rb = m_tdata[31:24];
                drive_sb.check_levels(got);
            end
            if (s_tvalid && s_tready)
            begin
                seen.mode       = s_tuser;
                seen.lf_pwm     = s_tdata[7:0];
                seen.lb_pwm     = s_tdata[15:8];
                seen.rf_pwm     = s_tdata[23:16];
                seen.rb_pwm     = s_tdata[31:24];
                seen.turn_left  = s_tdata[32];
                seen.turn_right = s_tdata[33];
                seen.pulse_req  = s_tdata[35:34];
                seen.disconnect = s_tdata[36];
                seen.on_time    = s_tdata[52:37];
                seen.off_time   = s_tdata[68:53];
                drive_sb.note_item(seen);
            end
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one; now and then a calm stretch
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if (r < 3)
        begin
            calm = $urandom_range(20, 100);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Stall the result side at random
    initial
    begin
        m_tready = 1'b0;
        rx_stall = 0;
        rx_calm  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_stall != 0)
            begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall = pick_gap(rx_calm);
            end
        end
    end

    // Tick beat; every other field is noise the block must ignore
    function automatic item_t tick_beat();
        item_t      it;
        logic [95:0] noise;
        noise   = {$urandom, $urandom, $urandom};
        it      = noise[$bits(item_t)-1:0];
        it.mode = MODE_TICK;
        return it;
    endfunction

    function automatic item_t cmd_beat(input logic [PWM_W-1:0] lf, input logic [PWM_W-1:0] lb,
                                       input logic [PWM_W-1:0] rf, input logic [PWM_W-1:0] rb,
                                       input logic tl, input logic tr,
                                       input logic [REQ_W-1:0] req, input logic disc,
                                       input logic [TIME_W-1:0] on_ms,
                                       input logic [TIME_W-1:0] off_ms);
        item_t it;
        it.mode       = MODE_CMD;
        it.lf_pwm     = lf;
        it.lb_pwm     = lb;
        it.rf_pwm     = rf;
        it.rb_pwm     = rb;
        it.turn_left  = tl;
        it.turn_right = tr;
        it.pulse_req  = req;
        it.disconnect = disc;
        it.on_time    = on_ms;
        it.off_time   = off_ms;
        return it;
    endfunction

    function automatic logic [PWM_W-1:0] rand_pwm();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return '0;
        if (r == 4)
            return '1;
        return PWM_W'($urandom_range(1, 255));
    endfunction

    // Phase lengths: mostly short so the turn toggles often
    function automatic logic [TIME_W-1:0] rand_phase_ms();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return '0;
        if (r < 9)
            return TIME_W'($urandom_range(1, 8));
        return TIME_W'($urandom_range(0, 65535));
    endfunction

    function automatic item_t rand_command();
        item_t       it;
        int unsigned r;
        it      = tick_beat();
        it.mode = MODE_CMD;
        it.lf_pwm = rand_pwm();
        it.lb_pwm = rand_pwm();
        it.rf_pwm = rand_pwm();
        it.rb_pwm = rand_pwm();
        // Favour continuing the last turn
        if ($urandom_range(0, 1) == 0)
            last_turn = 2'($urandom_range(0, 3));
        {it.turn_right, it.turn_left} = last_turn;
        r = $urandom_range(0, 9);
        if (r < 2)
            it.pulse_req = PULSE_OFF;
        else if (r < 6)
            it.pulse_req = PULSE_ON;
        else if (r < 9)
            it.pulse_req = PULSE_KEEP;
        else
            it.pulse_req = PULSE_KEEP_ALT;
        it.disconnect = ($urandom_range(0, 19) == 0);
        it.on_time    = rand_phase_ms();
        it.off_time   = rand_phase_ms();
        return it;
    endfunction

    // Offer one beat after a random gap; entered and left at a falling edge
    task automatic send_beat(input item_t it);
        int unsigned gap;
        gap = pick_gap(tx_calm);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {3'b000, it.off_time, it.on_time, it.disconnect, it.pulse_req,
                     it.turn_right, it.turn_left, it.rb_pwm, it.rf_pwm, it.lb_pwm, it.lf_pwm};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (drive_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid   <= 1'b0;
        cur_timeout = value;
    endtask

    task automatic run_directed();
        // Idle command, then forward winning over backward, then the smallest levels
        send_beat(cmd_beat(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, PULSE_OFF, 1'b0, 16'd0, 16'd0));
        send_beat(cmd_beat(8'd255, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0, PULSE_KEEP, 1'b0,
                           16'd0, 16'd0));
        send_beat(cmd_beat(8'd0, 8'd1, 8'd1, 8'd0, 1'b0, 1'b0, PULSE_KEEP_ALT, 1'b0,
                           16'd0, 16'd0));
        send_beat(tick_beat());
        // Start a pulsed left turn and run out its on phase
        send_beat(cmd_beat(8'd200, 8'd0, 8'd0, 8'd100, 1'b1, 1'b0, PULSE_ON, 1'b0,
                           16'd2, 16'd3));
        repeat (2) send_beat(tick_beat());
        // Continued turn in the off phase: drives held, new levels come with the on phase
        send_beat(cmd_beat(8'd10, 8'd0, 8'd0, 8'd20, 1'b0, 1'b1, PULSE_KEEP, 1'b0,
                           16'd0, 16'd0));
        repeat (3) send_beat(tick_beat());
        // Switch pulsed mode off mid-turn; the rotation timer keeps toggling
        send_beat(cmd_beat(8'd30, 8'd0, 8'd40, 8'd0, 1'b0, 1'b1, PULSE_OFF, 1'b0,
                           16'd0, 16'd0));
        repeat (3) send_beat(tick_beat());
        // Disconnect with pulsed mode requested on
        send_beat(cmd_beat(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, PULSE_ON, 1'b1,
                           16'hFFFF, 16'hFFFF));
        send_beat(tick_beat());
        // All fields at their top, turn still held from before the disconnect
        send_beat(cmd_beat(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, PULSE_KEEP, 1'b0,
                           16'hFFFF, 16'hFFFF));
        send_beat(tick_beat());
        send_beat(cmd_beat(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, PULSE_OFF, 1'b0, 16'd1, 16'd1));
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned sent;
        int unsigned len;
        int unsigned r;
        sent = 0;
        while (sent < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                // Run of ticks, sometimes long enough for a deadman to fire
                if (cur_timeout <= 300 && $urandom_range(0, 2) == 0)
                    len = cur_timeout + 2;
                else
                    len = $urandom_range(5, 20);
                // Keep within the phase budget
                if (len > budget - sent)
                    len = budget - sent;
                repeat (len) send_beat(tick_beat());
                sent += len;
            end
            else if (r < 45)
            begin
                send_beat(tick_beat());
                sent++;
            end
            else
            begin
                send_beat(rand_command());
                sent++;
            end
        end
    endtask

    initial
    begin
        drive_sb    = new();
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tuser     = MODE_CMD;
        s_tdata     = '0;
        tx_calm     = 0;
        last_turn   = '0;
        cur_timeout = TIMEOUT_RESET;
        phase_timeout[0] = 16'd0;
        phase_timeout[1] = 16'd1;
        phase_timeout[2] = 16'd3;
        phase_timeout[3] = 16'd250;
        phase_timeout[4] = 16'hFFFF;
        phase_timeout[5] = 16'd12;
        phase_timeout[6] = TIME_W'($urandom_range(2, 40));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed beats run on the reset deadman period
        run_directed();

        // Random phases, each on its own deadman period
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_timeout(phase_timeout[p]);
            run_random(ITEM_BUDGET / NUM_PHASES);
        end
        wait_idle();

        if (drive_sb.failed())
            $display("tb_dual_motor_drive_with_pulsed_turn: FAIL");
        else
            $display("tb_dual_motor_drive_with_pulsed_turn: PASS");
        $finish;
    end

endmodule
